/* sv/qrs_pkg.sv */
// Package for the quadratic root solver: widths, root-count codes and the
// context word that travels down the pipeline. No dependencies.
package qrs_pkg;

	localparam int COEF_W  = 32;
	localparam int FRAC_W  = 16;
	localparam int TOL_W   = 16;
	localparam int ADDR_W  = 3;
	localparam int SQ_BITS = 33;   // bits of the integer square root
	localparam int REM_W   = 67;   // square root remainder
	localparam int DISC_W  = 66;   // discriminant magnitude
	localparam int BASE_W  = 34;   // -b or -c, signed
	localparam int NUM_W   = 36;   // -b +/- sqrt(D), signed
	localparam int DMAG_W  = 34;   // |b| or 2|a|
	localparam int DV_W    = 35;   // divisor 2*dmag
	localparam int QN_W    = 52;   // dividend and quotient bits

	localparam logic [ADDR_W-1:0] REG_ZERO_TOL = '0;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

	typedef enum logic [1:0] {
		CNT_NONE = 2'd0,
		CNT_ONE  = 2'd1,
		CNT_TWO  = 2'd2,
		CNT_INF  = 2'd3
	} count_t;

	typedef struct packed {
		count_t kind;
		logic dneg;
		logic [DMAG_W-1:0] dmag;
		logic signed [BASE_W-1:0] base;
		logic [TOL_W-1:0] tol;
	} ctx_t;

endpackage

/* sv/qrs_eqn_if.sv */
// Input channel of the quadratic root solver: coefficients a, b, c.
// Depends on qrs_pkg.
interface qrs_eqn_if;
	logic valid;
	logic ready;
	logic signed [qrs_pkg::COEF_W-1:0] coef_a;
	logic signed [qrs_pkg::COEF_W-1:0] coef_b;
	logic signed [qrs_pkg::COEF_W-1:0] coef_c;
	modport source(output valid, coef_a, coef_b, coef_c, input ready);
	modport sink(input valid, coef_a, coef_b, coef_c, output ready);
endinterface

/* sv/qrs_sol_if.sv */
// Output channel of the quadratic root solver: count code, roots, flag.
// Depends on qrs_pkg.
interface qrs_sol_if;
	logic valid;
	logic ready;
	logic [1:0] root_count;
	logic signed [qrs_pkg::COEF_W-1:0] root_low;
	logic signed [qrs_pkg::COEF_W-1:0] root_high;
	logic saturated;
	modport source(output valid, root_count, root_low, root_high, saturated, input ready);
	modport sink(input valid, root_count, root_low, root_high, saturated, output ready);
endinterface

/* sv/quadratic_root_solver_unit.sv */
// Top level of the quadratic root solver: a fully pipelined Q16.16 solver.
// Depends on qrs_pkg, qrs_eqn_if and qrs_sol_if.
//
//  channel | direction | word
//  eqn     | in        | coef_a, coef_b, coef_c
//  sol     | out       | root_count, root_low, root_high, saturated
//  APB     | in        | zero_tolerance at address 0
//
// One word is accepted per cycle while the output is not stalled. Stages: input,
// multiply, discriminant, 33 square root stages, numerator, 52 divider stages and
// the output register. The whole pipeline advances when the output register is
// empty or being taken, so a stall holds every stage in place.
// Reset clears the valid bits and sets zero_tolerance to 1.
module quadratic_root_solver_unit (
	input  logic clk,
	input  logic arst_n,
	qrs_eqn_if.sink eqn,
	qrs_sol_if.source sol,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [qrs_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int W = qrs_pkg::COEF_W;

	logic [qrs_pkg::TOL_W-1:0] tol_q;
	logic adv;
	logic out_v_q;

	assign pready = 1'b1;
	assign prdata = {{(32-qrs_pkg::TOL_W){1'b0}}, tol_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= qrs_pkg::TOL_RESET;
		end else if (psel && penable && pwrite && paddr == qrs_pkg::REG_ZERO_TOL) begin
			tol_q <= pwdata[qrs_pkg::TOL_W-1:0];
		end
	end

	assign adv = !out_v_q || sol.ready;
	assign eqn.ready = adv;

	function automatic logic near_zero(input logic [W-1:0] mag,
			input logic [qrs_pkg::TOL_W-1:0] tol);
		near_zero = (mag == '0) || (mag < {{(W-qrs_pkg::TOL_W){1'b0}}, tol});
	endfunction

	// Stage 1: input register.
	logic v_s1;
	logic signed [W-1:0] a_s1, b_s1, c_s1;
	logic [qrs_pkg::TOL_W-1:0] tol_s1;

	// Stage 2: magnitudes, near-zero tests and products.
	logic v_s2;
	logic sa_s2, sb_s2, sc_s2, an_s2, bn_s2, cn_s2;
	logic [W-1:0] ma_s2, mb_s2;
	logic signed [W-1:0] b_s2, c_s2;
	logic [2*W-1:0] bb_s2, ac_s2;
	logic [qrs_pkg::TOL_W-1:0] tol_s2;

	logic [W-1:0] ma, mb, mc;
	assign ma = a_s1[W-1] ? W'(-a_s1) : a_s1;
	assign mb = b_s1[W-1] ? W'(-b_s1) : b_s1;
	assign mc = c_s1[W-1] ? W'(-c_s1) : c_s1;

	// Stage 3 and the square root stages.
	logic sq_v_s [0:qrs_pkg::SQ_BITS];
	logic [qrs_pkg::REM_W-1:0] sq_rem_s [0:qrs_pkg::SQ_BITS];
	logic [qrs_pkg::SQ_BITS-1:0] sq_root_s [0:qrs_pkg::SQ_BITS];
	qrs_pkg::ctx_t sq_ctx_s [0:qrs_pkg::SQ_BITS];

	logic [2*W+1:0] ac4;
	logic signed [qrs_pkg::DISC_W:0] dsum;
	logic [qrs_pkg::DISC_W-1:0] dmag;
	logic dnear;
	qrs_pkg::ctx_t ctx3;

	always_comb begin
		ac4 = {ac_s2, 2'b00};
		if (sa_s2 == sc_s2)
			dsum = $signed({3'b000, bb_s2}) - $signed({1'b0, ac4});
		else
			dsum = $signed({3'b000, bb_s2}) + $signed({1'b0, ac4});
		dmag = dsum[qrs_pkg::DISC_W] ? qrs_pkg::DISC_W'(-dsum)
			: dsum[qrs_pkg::DISC_W-1:0];
		dnear = (dmag == '0) || (dmag < {{(qrs_pkg::DISC_W-qrs_pkg::TOL_W-qrs_pkg::FRAC_W){1'b0}},
			tol_s2, {qrs_pkg::FRAC_W{1'b0}}});
		ctx3.tol = tol_s2;
		if (an_s2) begin
			ctx3.kind = bn_s2 ? (cn_s2 ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE) : qrs_pkg::CNT_ONE;
			ctx3.dneg = sb_s2;
			ctx3.dmag = {2'b00, mb_s2};
			ctx3.base = -$signed({{2{c_s2[W-1]}}, c_s2});
		end else begin
			if (dnear)
				ctx3.kind = qrs_pkg::CNT_ONE;
			else if (!dsum[qrs_pkg::DISC_W])
				ctx3.kind = qrs_pkg::CNT_TWO;
			else
				ctx3.kind = qrs_pkg::CNT_NONE;
			ctx3.dneg = sa_s2;
			ctx3.dmag = {1'b0, ma_s2, 1'b0};
			ctx3.base = -$signed({{2{b_s2[W-1]}}, b_s2});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			sq_v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s1 <= eqn.valid;
			v_s2 <= v_s1;
			sq_v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= eqn.coef_a;
			b_s1 <= eqn.coef_b;
			c_s1 <= eqn.coef_c;
			tol_s1 <= tol_q;
			sa_s2 <= a_s1[W-1];
			sb_s2 <= b_s1[W-1];
			sc_s2 <= c_s1[W-1];
			an_s2 <= near_zero(ma, tol_s1);
			bn_s2 <= near_zero(mb, tol_s1);
			cn_s2 <= near_zero(mc, tol_s1);
			ma_s2 <= ma;
			mb_s2 <= mb;
			b_s2 <= b_s1;
			c_s2 <= c_s1;
			bb_s2 <= mb * mb;
			ac_s2 <= ma * mc;
			tol_s2 <= tol_s1;
			sq_ctx_s[0] <= ctx3;
			sq_root_s[0] <= '0;
			sq_rem_s[0] <= (ctx3.kind == qrs_pkg::CNT_TWO) ? {1'b0, dmag} : '0;
		end
	end

	// Square root: one result bit per stage, remainder kept as D - r^2.
	for (genvar k = 0; k < qrs_pkg::SQ_BITS; k++) begin : g_sqrt
		localparam int I = qrs_pkg::SQ_BITS - 1 - k;
		logic [qrs_pkg::REM_W-1:0] trial;
		logic take;
		assign trial = ({{(qrs_pkg::REM_W-qrs_pkg::SQ_BITS){1'b0}}, sq_root_s[k]} << (I + 1))
			+ (qrs_pkg::REM_W'(1) << (2 * I));
		assign take = sq_rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v_s[k+1] <= 1'b0;
			else if (adv)
				sq_v_s[k+1] <= sq_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_ctx_s[k+1] <= sq_ctx_s[k];
				sq_rem_s[k+1] <= take ? sq_rem_s[k] - trial : sq_rem_s[k];
				sq_root_s[k+1] <= take ? sq_root_s[k] | (qrs_pkg::SQ_BITS'(1) << I) : sq_root_s[k];
			end
		end
	end

	// Numerators and the two dividers that share a divisor.
	logic dv_v_s [0:qrs_pkg::QN_W];
	qrs_pkg::ctx_t dv_ctx_s [0:qrs_pkg::QN_W];
	logic [qrs_pkg::DV_W-1:0] dv_s [0:qrs_pkg::QN_W];
	logic [1:0] dv_sgn_s [0:qrs_pkg::QN_W];
	logic [qrs_pkg::DV_W-1:0] dv_rem_s [0:qrs_pkg::QN_W][2];
	logic [qrs_pkg::QN_W-1:0] dv_n_s [0:qrs_pkg::QN_W][2];
	logic [qrs_pkg::QN_W-1:0] dv_q_s [0:qrs_pkg::QN_W][2];

	qrs_pkg::ctx_t cq;
	logic signed [qrs_pkg::NUM_W-1:0] num [2];
	logic [qrs_pkg::NUM_W-1:0] nmag [2];

	always_comb begin
		cq = sq_ctx_s[qrs_pkg::SQ_BITS];
		num[0] = $signed({{2{cq.base[qrs_pkg::BASE_W-1]}}, cq.base})
			- $signed({3'b000, sq_root_s[qrs_pkg::SQ_BITS]});
		num[1] = $signed({{2{cq.base[qrs_pkg::BASE_W-1]}}, cq.base})
			+ $signed({3'b000, sq_root_s[qrs_pkg::SQ_BITS]});
		for (int l = 0; l < 2; l++)
			nmag[l] = num[l][qrs_pkg::NUM_W-1] ? qrs_pkg::NUM_W'(-num[l]) : num[l];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v_s[0] <= 1'b0;
		else if (adv)
			dv_v_s[0] <= sq_v_s[qrs_pkg::SQ_BITS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_ctx_s[0] <= cq;
			dv_s[0] <= {cq.dmag, 1'b0};
			for (int l = 0; l < 2; l++) begin
				dv_sgn_s[0][l] <= num[l][qrs_pkg::NUM_W-1] ^ cq.dneg;
				dv_rem_s[0][l] <= '0;
				dv_q_s[0][l] <= '0;
				dv_n_s[0][l] <= {1'b0, nmag[l][qrs_pkg::DMAG_W-1:0], {(qrs_pkg::FRAC_W+1){1'b0}}}
					+ {{(qrs_pkg::QN_W-qrs_pkg::DMAG_W){1'b0}}, cq.dmag};
			end
		end
	end

	// Restoring division: one quotient bit per stage, dividend MSB first.
	for (genvar j = 0; j < qrs_pkg::QN_W; j++) begin : g_div
		logic [qrs_pkg::DV_W:0] sh [2];
		logic ge [2];
		always_comb begin
			for (int l = 0; l < 2; l++) begin
				sh[l] = {dv_rem_s[j][l], dv_n_s[j][l][qrs_pkg::QN_W-1]};
				ge[l] = sh[l] >= {1'b0, dv_s[j]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[j+1] <= 1'b0;
			else if (adv)
				dv_v_s[j+1] <= dv_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_ctx_s[j+1] <= dv_ctx_s[j];
				dv_s[j+1] <= dv_s[j];
				dv_sgn_s[j+1] <= dv_sgn_s[j];
				for (int l = 0; l < 2; l++) begin
					dv_rem_s[j+1][l] <= ge[l] ? qrs_pkg::DV_W'(sh[l] - {1'b0, dv_s[j]})
						: sh[l][qrs_pkg::DV_W-1:0];
					dv_n_s[j+1][l] <= {dv_n_s[j][l][qrs_pkg::QN_W-2:0], 1'b0};
					dv_q_s[j+1][l] <= {dv_q_s[j][l][qrs_pkg::QN_W-2:0], ge[l]};
				end
			end
		end
	end

	// Final: snap to zero, saturate, sort and pack.
	qrs_pkg::ctx_t cf;
	logic [qrs_pkg::QN_W-1:0] qv [2];
	logic rneg [2];
	logic rsat [2];
	logic signed [W-1:0] rv [2];
	logic [qrs_pkg::QN_W-1:0] lim;
	logic [1:0] cnt_d;
	logic signed [W-1:0] lo_d, hi_d;
	logic sat_d;

	always_comb begin
		cf = dv_ctx_s[qrs_pkg::QN_W];
		for (int l = 0; l < 2; l++) begin
			qv[l] = dv_q_s[qrs_pkg::QN_W][l];
			if (qv[l] < {{(qrs_pkg::QN_W-qrs_pkg::TOL_W){1'b0}}, cf.tol})
				qv[l] = '0;
			rneg[l] = dv_sgn_s[qrs_pkg::QN_W][l] && (qv[l] != '0);
			lim = rneg[l] ? (qrs_pkg::QN_W'(1) << (W - 1))
				: (qrs_pkg::QN_W'(1) << (W - 1)) - qrs_pkg::QN_W'(1);
			rsat[l] = qv[l] > lim;
			if (rsat[l])
				qv[l] = lim;
			rv[l] = rneg[l] ? W'(-qv[l][W-1:0]) : qv[l][W-1:0];
		end
		cnt_d = cf.kind;
		lo_d = '0;
		hi_d = '0;
		sat_d = 1'b0;
		case (cf.kind)
			qrs_pkg::CNT_ONE: begin
				lo_d = rv[0];
				sat_d = rsat[0];
			end
			qrs_pkg::CNT_TWO: begin
				lo_d = (rv[0] <= rv[1]) ? rv[0] : rv[1];
				hi_d = (rv[0] <= rv[1]) ? rv[1] : rv[0];
				sat_d = rsat[0] | rsat[1];
			end
			default: begin
				lo_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (adv)
			out_v_q <= dv_v_s[qrs_pkg::QN_W];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sol.root_count <= cnt_d;
			sol.root_low <= lo_d;
			sol.root_high <= hi_d;
			sol.saturated <= sat_d;
		end
	end

	assign sol.valid = out_v_q;

endmodule

/* sv/qrs_chk.sv */
// Port-level checker for the quadratic root solver, bound to the top level.
// Depends on qrs_pkg and quadratic_root_solver_unit.
module qrs_chk (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input logic ready,
	input logic [1:0] root_count,
	input logic signed [qrs_pkg::COEF_W-1:0] root_low,
	input logic signed [qrs_pkg::COEF_W-1:0] root_high,
	input logic saturated
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(root_low) && $stable(root_high))
		else $error("stalled output word changed");

	a_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && root_count != qrs_pkg::CNT_TWO |-> root_high == '0)
		else $error("root_high nonzero without two roots");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		valid && root_count == qrs_pkg::CNT_TWO |-> root_low <= root_high)
		else $error("roots not ascending");

	a_absent: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (root_count == qrs_pkg::CNT_NONE || root_count == qrs_pkg::CNT_INF)
		|-> root_low == '0 && !saturated)
		else $error("root or flag reported without a root");

endmodule

bind quadratic_root_solver_unit qrs_chk u_qrs_chk (
	.clk(clk),
	.arst_n(arst_n),
	.valid(sol.valid),
	.ready(sol.ready),
	.root_count(sol.root_count),
	.root_low(sol.root_low),
	.root_high(sol.root_high),
	.saturated(sol.saturated)
);

/* dv/tb_top.sv */
// Self-checking testbench for quadratic_root_solver_unit: drives random and directed
// equations through the eqn channel and checks each solution word against a predictor.
// Depends on qrs_pkg, qrs_eqn_if, qrs_sol_if and the solver RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		qrs_pkg::count_t count;
		logic [qrs_pkg::COEF_W-1:0] low;
		logic [qrs_pkg::COEF_W-1:0] high;
		logic sat;
	} solution_t;

	localparam longint CYCLE_LIMIT = 2000000;

	// One quotient rounded half away from zero, snapped near zero, then clipped.
	function automatic logic [qrs_pkg::COEF_W-1:0] divide_root(input bit nneg,
			input logic [127:0] nmag, input bit dneg, input logic [63:0] dmag,
			input logic [qrs_pkg::TOL_W-1:0] tol, inout logic sat);
		logic [127:0] n;
		logic [127:0] q;
		logic [127:0] lim;
		bit neg;
		n = (nmag << (qrs_pkg::FRAC_W + 1)) + {64'd0, dmag};
		q = n / ({64'd0, dmag} << 1);
		neg = nneg != dneg;
		if (q < {112'd0, tol})
			q = '0;
		if (q == 0)
			neg = 0;
		lim = neg ? (128'd1 << (qrs_pkg::COEF_W - 1)) : (128'd1 << (qrs_pkg::COEF_W - 1)) - 1;
		if (q > lim) begin
			q = lim;
			sat = 1;
		end
		return neg ? -q[qrs_pkg::COEF_W-1:0] : q[qrs_pkg::COEF_W-1:0];
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [127:0] d);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			t = r | (64'd1 << i);
			if ({64'd0, t} * {64'd0, t} <= d)
				r = t;
		end
		return r;
	endfunction

	function automatic solution_t solve_equation(input logic signed [qrs_pkg::COEF_W-1:0] a,
			input logic signed [qrs_pkg::COEF_W-1:0] b,
			input logic signed [qrs_pkg::COEF_W-1:0] c,
			input logic [qrs_pkg::TOL_W-1:0] tol);
		solution_t s;
		logic signed [127:0] av, bv, cv, neg_b, neg_c, r1n, r2n;
		logic [63:0] am, bm, cm, root_s;
		logic [127:0] sq, prod4, dmag;
		logic [qrs_pkg::COEF_W-1:0] r1, r2;
		bit dneg, pneg;
		av = a;
		bv = b;
		cv = c;
		am = a < 0 ? -av[63:0] : av[63:0];
		bm = b < 0 ? -bv[63:0] : bv[63:0];
		cm = c < 0 ? -cv[63:0] : cv[63:0];
		neg_b = -bv;
		neg_c = -cv;
		s = '{qrs_pkg::CNT_NONE, '0, '0, 1'b0};
		if (am == 0 || am < tol) begin
			if (bm == 0 || bm < tol) begin
				s.count = (cm == 0 || cm < tol) ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
			end else begin
				s.low = divide_root(neg_c < 0, neg_c < 0 ? -neg_c : neg_c, b < 0, bm, tol,
					s.sat);
				s.count = qrs_pkg::CNT_ONE;
			end
		end else begin
			sq = {64'd0, bm} * {64'd0, bm};
			prod4 = ({64'd0, am} * {64'd0, cm}) << 2;
			pneg = ((a < 0) == (c < 0)) && prod4 != 0;
			if (pneg) begin
				dneg = sq < prod4;
				dmag = dneg ? prod4 - sq : sq - prod4;
			end else begin
				dneg = 0;
				dmag = sq + prod4;
			end
			if (dmag == 0 || dmag < ({112'd0, tol} << qrs_pkg::FRAC_W)) begin
				s.low = divide_root(neg_b < 0, neg_b < 0 ? -neg_b : neg_b, a < 0, am << 1, tol,
					s.sat);
				s.count = qrs_pkg::CNT_ONE;
			end else if (!dneg) begin
				root_s = floor_sqrt(dmag);
				r1n = neg_b - $signed({64'd0, root_s});
				r2n = neg_b + $signed({64'd0, root_s});
				r1 = divide_root(r1n < 0, r1n < 0 ? -r1n : r1n, a < 0, am << 1, tol, s.sat);
				r2 = divide_root(r2n < 0, r2n < 0 ? -r2n : r2n, a < 0, am << 1, tol, s.sat);
				if ($signed(r1) <= $signed(r2)) begin
					s.low = r1;
					s.high = r2;
				end else begin
					s.low = r2;
					s.high = r1;
				end
				s.count = qrs_pkg::CNT_TWO;
			end
		end
		return s;
	endfunction

	class solution_board;
		solution_t pending[$];
		logic [qrs_pkg::TOL_W-1:0] tol = qrs_pkg::TOL_RESET;
		int errors = 0;

		function void note_equation(logic [qrs_pkg::COEF_W-1:0] a,
				logic [qrs_pkg::COEF_W-1:0] b, logic [qrs_pkg::COEF_W-1:0] c);
			pending.push_back(solve_equation(a, b, c, tol));
		endfunction

		function void check_solution(solution_t got);
			solution_t exp_s;
			if (pending.size() == 0) begin
				$display("%0t: unexpected solution word count=%0d", $realtime, got.count);
				errors++;
				return;
			end
			exp_s = pending.pop_front();
			if (got.count !== exp_s.count) begin
				$display("%0t: root_count expected %0d got %0d", $realtime, exp_s.count, got.count);
				errors++;
			end
			if (got.low !== exp_s.low) begin
				$display("%0t: root_low expected %h got %h", $realtime, exp_s.low, got.low);
				errors++;
			end
			if (got.high !== exp_s.high) begin
				$display("%0t: root_high expected %h got %h", $realtime, exp_s.high, got.high);
				errors++;
			end
			if (got.sat !== exp_s.sat) begin
				$display("%0t: saturated expected %b got %b", $realtime, exp_s.sat, got.sat);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [qrs_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	longint cycles = 0;
	solution_board board = new();

	qrs_eqn_if eqn();
	qrs_sol_if sol();

	quadratic_root_solver_unit dut (
		.clk(clk), .arst_n(arst_n), .eqn(eqn.sink), .sol(sol.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		eqn.valid = 0;
		eqn.coef_a = '0;
		eqn.coef_b = '0;
		eqn.coef_c = '0;
		sol.ready = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("quadratic_root_solver_unit test failed");
			$finish;
		end
	end

	// Receiver: a random duty pattern that is redrawn periodically, plus one long hold-off
	// while the sender keeps offering words, so the pipeline fills and stalls.
	initial begin
		int period, duty, hold;
		period = 1;
		duty = 1;
		hold = 0;
		forever begin
			@(negedge clk);
			if (cycles % 200 == 0) begin
				period = $urandom_range(1, 8);
				duty = ($urandom_range(0, 3) == 0) ? period : $urandom_range(1, period);
			end
			if (cycles == 200)
				hold = 400;
			if (hold > 0) begin
				hold--;
				sol.ready = 0;
			end else begin
				sol.ready = (cycles % period) < duty;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && sol.valid && sol.ready)
			board.check_solution('{qrs_pkg::count_t'(sol.root_count), sol.root_low,
				sol.root_high, sol.saturated});
	end

	task automatic write_tolerance(input logic [qrs_pkg::TOL_W-1:0] value);
		@(negedge clk);
		psel = 1;
		pwrite = 1;
		penable = 0;
		paddr = qrs_pkg::REG_ZERO_TOL;
		pwdata = {16'd0, value};
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		board.tol = value;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	task automatic send_equation(input logic [qrs_pkg::COEF_W-1:0] a,
			input logic [qrs_pkg::COEF_W-1:0] b, input logic [qrs_pkg::COEF_W-1:0] c);
		@(negedge clk);
		eqn.valid = 1;
		eqn.coef_a = a;
		eqn.coef_b = b;
		eqn.coef_c = c;
		@(posedge clk);
		while (!eqn.ready) @(posedge clk);
		board.note_equation(a, b, c);
	endtask

	task automatic pause_sender(input int n);
		repeat (n) begin
			@(negedge clk);
			eqn.valid = 0;
		end
	endtask

	// Small integer-valued coefficient in Q16.16, sometimes with a random fraction.
	function automatic logic [qrs_pkg::COEF_W-1:0] small_coef(input int span);
		int v;
		v = $urandom_range(0, 2 * span) - span;
		return (v <<< qrs_pkg::FRAC_W)
			+ (($urandom_range(0, 1) == 1) ? $urandom_range(0, 65535) : 0);
	endfunction

	task automatic send_random_equation(input logic [qrs_pkg::TOL_W-1:0] tol);
		logic signed [qrs_pkg::COEF_W-1:0] a, b, c;
		int k, r1, r2;
		case ($urandom_range(0, 5))
			0: begin
				a = $urandom;
				b = $urandom;
				c = $urandom;
			end
			1: begin
				a = small_coef(8);
				b = small_coef(64);
				c = small_coef(64);
			end
			2: begin
				// Built from chosen integer roots, so the discriminant is a square.
				k = $urandom_range(1, 4) * (($urandom_range(0, 1) == 1) ? 1 : -1);
				r1 = $urandom_range(0, 40) - 20;
				r2 = $urandom_range(0, 40) - 20;
				a = k <<< qrs_pkg::FRAC_W;
				b = (-k * (r1 + r2)) <<< qrs_pkg::FRAC_W;
				c = (k * r1 * r2) <<< qrs_pkg::FRAC_W;
			end
			3: begin
				a = $urandom_range(0, 2 * tol + 2) - tol - 1;
				b = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 2 * tol + 2) - tol - 1;
				c = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 2 * tol + 2) - tol - 1;
			end
			4: begin
				a = $urandom_range(1, 255) * (($urandom_range(0, 1) == 1) ? 1 : -1);
				b = $urandom;
				c = small_coef(4);
			end
			default: begin
				a = ($urandom_range(0, 1) == 1) ? 32'sh7fffffff : 32'sh80000000;
				b = $urandom;
				c = ($urandom_range(0, 1) == 1) ? $urandom : small_coef(2);
			end
		endcase
		send_equation(a, b, c);
	endtask

	task automatic run_random(input int count, input logic [qrs_pkg::TOL_W-1:0] tol);
		int burst;
		int sent;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 30);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_random_equation(tol);
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 12));
		end
		pause_sender(1);
	endtask

	task automatic drain;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		logic [qrs_pkg::TOL_W-1:0] settings[5];
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed words under the reset tolerance.
		send_equation(32'h0, 32'h0, 32'h0);
		send_equation(32'h0, 32'h0, 32'h5_0000);
		send_equation(32'h0, 32'h1_0000, 32'hfffe_0000);
		send_equation(32'h0, 32'h1, 32'h7fffffff);
		send_equation(32'h1_0000, 32'h0, 32'hfffc_0000);
		send_equation(32'h1_0000, 32'hfffe_0000, 32'h1_0000);
		send_equation(32'h1_0000, 32'h0, 32'h1_0000);
		send_equation(32'h1_0000, 32'h0, 32'hffffffff);
		send_equation(32'h80000000, 32'h80000000, 32'h80000000);
		send_equation(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_equation(32'h1, 32'h7fffffff, 32'h80000000);
		send_equation(32'h80000000, 32'h0, 32'h7fffffff);
		send_equation(32'hffff_0000, 32'h3_0000, 32'h0);
		send_equation(32'h1, 32'h80000000, 32'h0);
		send_equation(32'hffffffff, 32'hffffffff, 32'hffffffff);
		send_equation(32'h2_0000, 32'h4_0000, 32'h2_0001);
		pause_sender(1);
		run_random(300, board.tol);
		drain();

		settings = '{16'd0, 16'hffff, 16'd300, 16'd1, 16'($urandom)};
		foreach (settings[i]) begin
			write_tolerance(settings[i]);
			if (i == 0) begin
				send_equation(32'h0, 32'h1, 32'h1);
				send_equation(32'h1, 32'h0, 32'h0);
				pause_sender(1);
			end
			run_random(260, settings[i]);
			drain();
		end

		if (board.errors == 0)
			$display("quadratic_root_solver_unit test passed");
		else
			$display("quadratic_root_solver_unit test failed");
		$finish;
	end
endmodule
